// ===== hw/rtl/blr_pkg.sv =====
// Shared types and constants of the bicubic line resampler.
// No dependencies; used by blr_mac and bicubic_line_resampler_top.
package blr_pkg;

    localparam int POS_W    = 11;
    localparam int SMP_W    = 8;
    localparam int TAPI_W   = 4;
    localparam int CNT_W    = 5;
    localparam int WGT_W    = 25;
    localparam int FRAC_BITS = 22;
    localparam int PROD_W   = SMP_W + 1 + WGT_W;
    // 16 taps of 8x25 bits plus rounding term, with headroom
    localparam int ACC_W    = PROD_W + CNT_W + 1;
    localparam int IDX_W    = POS_W + 1;

    localparam logic signed [ACC_W-1:0] ACC_INIT = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] ACC_MAX  = ACC_W'(255) << FRAC_BITS;

    typedef enum logic [1:0] {
        MODE_SAMPLE  = 2'd0,
        MODE_HEADER  = 2'd1,
        MODE_WEIGHT  = 2'd2,
        MODE_COMPUTE = 2'd3
    } mode_t;

    typedef struct packed {
        logic [POS_W-1:0] first;
        logic [CNT_W-1:0] len;
    } kern_t;

    typedef struct packed {
        logic clear;   // load rounding term into accumulator
        logic vld;     // operands valid this cycle
    } mac_ctl_t;

endpackage

// ===== hw/rtl/bicubic_line_resampler_top.sv =====
// Separable bicubic resampler pass: a store item is written as it is accepted; a compute
// item holds the input through the accept cycle, one header read, one tap per cycle
// through the line and weight memory read ports into the single shared
// multiply-accumulate unit, the drain of the last tap reads, and the result load. A
// result still waiting in the output register delays that load; otherwise the next
// item is accepted while a finished result waits.
// Depends on blr_pkg and blr_mac.
module bicubic_line_resampler_top
    import blr_pkg::*;
#(
    parameter int MAX_LINE = 2048,
    parameter int MAX_TAPS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              mode,
    input  logic [POS_W-1:0]        position,
    input  logic [SMP_W-1:0]        sample,
    input  logic [TAPI_W-1:0]       tap_index,
    input  logic [POS_W-1:0]        first_index,
    input  logic [CNT_W-1:0]        tap_count,
    input  logic signed [WGT_W-1:0] weight,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [POS_W-1:0]        position_res,
    output logic [SMP_W-1:0]        result_sample
);

    localparam int LINE_AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int TAP_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int WGT_AW  = LINE_AW + TAP_W;
    localparam int WGT_DEPTH = MAX_LINE << TAP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_TAP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // memories
    logic [SMP_W-1:0]        line_mem [MAX_LINE];
    kern_t                   kern_mem [MAX_LINE];
    logic signed [WGT_W-1:0] wgt_mem  [WGT_DEPTH];

    logic [SMP_W-1:0]        line_rd_reg;
    kern_t                   kern_rd_reg;
    logic signed [WGT_W-1:0] wgt_rd_reg;

    state_t           state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             s1_vld_reg, s1_vld_next;
    logic             out_valid_reg, out_valid_next;
    logic [POS_W-1:0] out_pos_reg, out_pos_next;
    logic [SMP_W-1:0] out_smp_reg, out_smp_next;

    logic             accept;
    logic             pos_ok;
    logic             tap_ok;
    logic [CNT_W-1:0] len_sat;
    logic [IDX_W-1:0] idx;
    logic             idx_ok;
    logic             issue;
    mac_ctl_t         mac_ctl;
    logic             mac_busy;
    logic [SMP_W-1:0] mac_result;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign pos_ok   = 32'(position) < MAX_LINE;
    assign tap_ok   = 32'(tap_index) < MAX_TAPS;
    assign len_sat  = (32'(tap_count) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : tap_count;
    assign idx      = IDX_W'(base_reg) + IDX_W'(j_reg);
    assign idx_ok   = 32'(idx) < MAX_LINE;

    // store writes
    always_ff @(posedge clk)
    begin
        if (accept && pos_ok)
        begin
            case (mode_t'(mode))
                MODE_SAMPLE:
                begin
                    line_mem[LINE_AW'(position)] <= sample;
                end
                MODE_HEADER:
                begin
                    kern_mem[LINE_AW'(position)] <= '{first: first_index, len: len_sat};
                end
                MODE_WEIGHT:
                begin
                    if (tap_ok)
                    begin
                        wgt_mem[{LINE_AW'(position), TAP_W'(tap_index)}] <= weight;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // registered reads
    always_ff @(posedge clk)
    begin
        kern_rd_reg <= kern_mem[LINE_AW'(position)];
        line_rd_reg <= line_mem[LINE_AW'(idx)];
        wgt_rd_reg  <= wgt_mem[WGT_AW'({LINE_AW'(pos_reg), TAP_W'(j_reg)})];
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        base_next      = base_reg;
        len_next       = len_reg;
        j_next         = j_reg;
        out_pos_next   = out_pos_reg;
        out_smp_next   = out_smp_reg;
        out_valid_next = out_valid_reg && out_stall;
        issue          = 1'b0;
        mac_ctl.clear  = 1'b0;
        mac_ctl.vld    = s1_vld_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode_t'(mode) == MODE_COMPUTE)
                begin
                    pos_next      = position;
                    mac_ctl.clear = 1'b1;
                    // out-of-line position sums no taps
                    state_next    = pos_ok ? ST_HDR : ST_DONE;
                end
            end
            ST_HDR:
            begin
                base_next  = kern_rd_reg.first;
                len_next   = kern_rd_reg.len;
                j_next     = '0;
                state_next = (kern_rd_reg.len == '0) ? ST_DRAIN : ST_TAP;
            end
            ST_TAP:
            begin
                issue  = 1'b1;
                j_next = j_reg + 1'b1;
                if (CNT_W'(j_reg + 1'b1) == len_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_vld_reg && !mac_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_reg;
                    out_smp_next   = mac_result;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s1_vld_next = issue && idx_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s1_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s1_vld_reg    <= s1_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        base_reg    <= base_next;
        len_reg     <= len_next;
        j_reg       <= j_next;
        out_pos_reg <= out_pos_next;
        out_smp_reg <= out_smp_next;
    end

    blr_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .smp    (line_rd_reg),
        .wgt    (wgt_rd_reg),
        .busy   (mac_busy),
        .result (mac_result)
    );

    assign out_valid     = out_valid_reg;
    assign position_res  = out_pos_reg;
    assign result_sample = out_smp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |-> $past(state_reg == ST_TAP))
        else $error("tap read outside tap loop");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAP) |-> (j_reg < len_reg))
        else $error("tap counter past kernel length");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mac_busy && !s1_vld_reg)
        else $error("taps still in flight while idle");

endmodule

// ===== hw/rtl/blr_mac.sv =====
// Shared multiply-accumulate unit with output clamp.
// Depends on blr_pkg.
module blr_mac
    import blr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_ctl_t                ctl,
    input  logic [SMP_W-1:0]        smp,
    input  logic signed [WGT_W-1:0] wgt,
    output logic                    busy,
    output logic [SMP_W-1:0]        result
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed({1'b0, smp}) * wgt;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = ACC_INIT;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= ACC_INIT;
        end
        else
        begin
            prod_vld_reg <= ctl.vld;
            acc_reg      <= acc_next;
        end
    end

    assign busy = prod_vld_reg;

    always_comb
    begin
        if (acc_reg <= 0)
        begin
            result = '0;
        end
        else if (acc_reg >= ACC_MAX)
        begin
            result = '1;
        end
        else
        begin
            result = acc_reg[FRAC_BITS +: SMP_W];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |-> !prod_vld_reg && !ctl.vld)
        else $error("accumulator cleared while taps in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        prod_vld_reg |-> $past(ctl.vld))
        else $error("product valid without operands");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> acc_reg == ACC_INIT)
        else $error("accumulator not loaded with rounding term");

endmodule
